// ===== sv/unix_time_to_calendar_assert.svh =====
// Assertion macros for the calendar converter.
// Define NO_ASSERTIONS to compile them out.
`ifndef UNIX_TIME_TO_CALENDAR_ASSERT_SVH
`define UNIX_TIME_TO_CALENDAR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define UCAL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define UCAL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UCAL_ASSERT(lbl, clk, rst, prop, msg)
`define UCAL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/ucal_pkg.sv =====
`default_nettype none
package ucal_pkg;

   localparam int SECS_W = 32;
   localparam int DAYS_W = 16;
   localparam int YEAR_W = 12;
   localparam int MON_W = 4;
   localparam int DAY_W = 5;
   localparam int HOUR_W = 5;
   localparam int MIN_W = 6;
   localparam int REM_W = 6;

   localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;
   localparam logic [6:0] EPOCH_MOD100 = 7'd70;
   localparam logic [8:0] EPOCH_MOD400 = 9'd370;
   localparam logic [6:0] LAST_MOD100 = 7'd99;
   localparam logic [8:0] LAST_MOD400 = 9'd399;
   localparam logic [8:0] YEAR_DAYS = 9'd365;
   localparam logic [8:0] LEAP_YEAR_DAYS = 9'd366;

   localparam logic [MON_W-1:0] MONTH_JAN = 4'd0;
   localparam logic [MON_W-1:0] MONTH_FEB = 4'd1;
   localparam logic [MON_W-1:0] MONTH_APR = 4'd3;
   localparam logic [MON_W-1:0] MONTH_JUN = 4'd5;
   localparam logic [MON_W-1:0] MONTH_SEP = 4'd8;
   localparam logic [MON_W-1:0] MONTH_NOV = 4'd10;
   localparam logic [MON_W-1:0] MONTH_DEC = 4'd11;

   // constant divide by reciprocal multiply:
   // x / 60 = (x >> 2) / 15, x / 24 = (x >> 3) / 3
   localparam int DIV_CNT_W = 1;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST_CNT = 1'b1;
   localparam int PROD_W = 2 * SECS_W;
   localparam int DIV60_PRE = 2;
   localparam int DIV24_PRE = 3;
   localparam logic [SECS_W-1:0] RECIP_15 = 32'h8888_8889;
   localparam int RECIP_15_SHIFT = 35;
   localparam logic [SECS_W-1:0] RECIP_3 = 32'hAAAA_AAAB;
   localparam int RECIP_3_SHIFT = 33;

   typedef enum logic [1:0] {
      DIV_SEC,
      DIV_MIN,
      DIV_HOUR
   } div_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_YEAR,
      ST_MONTH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic div_last;
      div_sel_type div_sel;
      logic year_step;
      logic month_step;
   } cmd_type;

   typedef struct packed {
      logic year_fit;
      logic month_fit;
   } status_type;

   function automatic logic [REM_W-1:0] divisor(input div_sel_type sel);
      logic [REM_W-1:0] d;
      unique case (sel)
         DIV_SEC: d = 6'd60;
         DIV_MIN: d = 6'd60;
         DIV_HOUR: d = 6'd24;
         default: d = 6'd60;
      endcase
      return d;
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] mon,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (mon) inside
         MONTH_FEB: len = leap ? 5'd29 : 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

// ===== sv/ucal_ctrl.sv =====
`default_nettype none
`include "unix_time_to_calendar_assert.svh"
module ucal_ctrl
   import ucal_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output cmd_type cmd,
   input  wire status_type status
);

   state_type state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   div_sel_type sel_ff, sel_in;
   logic div_last;

   assign div_last = (cnt_ff == DIV_LAST_CNT);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_DIV;
         ST_DIV: if (div_last && sel_ff == DIV_HOUR) state_in = ST_YEAR;
         ST_YEAR: if (status.year_fit) state_in = ST_MONTH;
         ST_MONTH: if (status.month_fit) state_in = ST_DONE;
         ST_DONE: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.div_sel = sel_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.div_last = div_last;
         end
         ST_YEAR: cmd.year_step = 1'b1;
         ST_MONTH: cmd.month_step = 1'b1;
         ST_DONE: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      sel_in = sel_ff;
      if (cmd.load) begin
         cnt_in = '0;
         sel_in = DIV_SEC;
      end else if (cmd.div_step) begin
         cnt_in = cnt_ff + 1'b1;
         if (div_last) begin
            unique case (sel_ff)
               DIV_SEC: sel_in = DIV_MIN;
               DIV_MIN: sel_in = DIV_HOUR;
               DIV_HOUR: sel_in = DIV_HOUR;
               default: sel_in = DIV_SEC;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         sel_ff <= DIV_SEC;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         sel_ff <= sel_in;
      end
   end

   `UCAL_ASSERT_ALWAYS(a_no_ready_with_result, clock, !(req_ready && rsp_valid),
      "ready and result valid together")
   `UCAL_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready,
      "new beat taken while busy")
   `UCAL_ASSERT(a_result_from_month, clock, reset,
      $rose(rsp_valid) |-> $past(state_ff == ST_MONTH),
      "result raised outside month phase")
   `UCAL_ASSERT(a_div_enter_year, clock, reset,
      $rose(cmd.year_step) |-> $past(cmd.div_last && sel_ff == DIV_HOUR),
      "year phase entered before hour divide ended")

endmodule
`default_nettype wire

// ===== sv/ucal_dp.sv =====
`default_nettype none
`include "unix_time_to_calendar_assert.svh"
module ucal_dp
   import ucal_pkg::*;
(
   input  wire logic clock,
   input  wire cmd_type cmd,
   output status_type status,
   input  wire logic [SECS_W-1:0] unix_seconds,
   output logic [YEAR_W-1:0] year_out,
   output logic [MON_W-1:0] month_out,
   output logic [DAY_W-1:0] day_out,
   output logic [HOUR_W-1:0] hour_out,
   output logic [MIN_W-1:0] minute_out,
   output logic [MIN_W-1:0] second_out
);

   logic [SECS_W-1:0] quo_ff, quo_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [REM_W-1:0] rem_in;
   logic [REM_W-1:0] sec_ff, min_ff;
   logic [HOUR_W-1:0] hr_ff;
   logic [YEAR_W-1:0] year_ff;
   logic [6:0] m100_ff;
   logic [8:0] m400_ff;
   logic [MON_W-1:0] mon_ff;

   logic [DAYS_W-1:0] days;
   logic leap;
   logic [8:0] ylen;
   logic [DAY_W-1:0] mlen;

   assign days = quo_ff[DAYS_W-1:0];
   assign leap = ((year_ff[1:0] == 2'd0) && (m100_ff != 7'd0)) || (m400_ff == 9'd0);
   assign ylen = leap ? LEAP_YEAR_DAYS : YEAR_DAYS;
   assign mlen = month_len(mon_ff, leap);
   assign status.year_fit = days < {{(DAYS_W-9){1'b0}}, ylen};
   assign status.month_fit = (mon_ff == MONTH_DEC) ||
                             (days < {{(DAYS_W-DAY_W){1'b0}}, mlen});

   // reciprocal divide: the product is registered first, then quotient and remainder
   // are taken from it; the remainder is below 64, so 6-bit math gives it exactly
   always_comb begin
      logic [PROD_W-1:0] q_full;
      if (cmd.div_sel == DIV_HOUR) begin
         prod_in = PROD_W'(quo_ff >> DIV24_PRE) * PROD_W'(RECIP_3);
         q_full = prod_ff >> RECIP_3_SHIFT;
      end else begin
         prod_in = PROD_W'(quo_ff >> DIV60_PRE) * PROD_W'(RECIP_15);
         q_full = prod_ff >> RECIP_15_SHIFT;
      end
      quo_in = q_full[SECS_W-1:0];
      rem_in = quo_ff[REM_W-1:0] - quo_in[REM_W-1:0] * divisor(cmd.div_sel);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         quo_ff <= unix_seconds;
         year_ff <= EPOCH_YEAR;
         m100_ff <= EPOCH_MOD100;
         m400_ff <= EPOCH_MOD400;
         mon_ff <= MONTH_JAN;
      end else if (cmd.div_step) begin
         if (cmd.div_last) begin
            quo_ff <= quo_in;
            case (cmd.div_sel)
               DIV_SEC: sec_ff <= rem_in;
               DIV_MIN: min_ff <= rem_in;
               default: hr_ff <= rem_in[HOUR_W-1:0];
            endcase
         end else begin
            prod_ff <= prod_in;
         end
      end else if (cmd.year_step && !status.year_fit) begin
         quo_ff <= {{(SECS_W-DAYS_W){1'b0}}, days - {{(DAYS_W-9){1'b0}}, ylen}};
         year_ff <= year_ff + 1'b1;
         m100_ff <= (m100_ff == LAST_MOD100) ? 7'd0 : m100_ff + 1'b1;
         m400_ff <= (m400_ff == LAST_MOD400) ? 9'd0 : m400_ff + 1'b1;
      end else if (cmd.month_step && !status.month_fit) begin
         quo_ff <= {{(SECS_W-DAYS_W){1'b0}}, days - {{(DAYS_W-DAY_W){1'b0}}, mlen}};
         mon_ff <= mon_ff + 1'b1;
      end
   end

   assign year_out = year_ff;
   assign month_out = mon_ff + 1'b1;
   assign day_out = days[DAY_W-1:0] + 1'b1;
   assign hour_out = hr_ff;
   assign minute_out = min_ff;
   assign second_out = sec_ff;

   `UCAL_ASSERT_ALWAYS(a_day_in_month, clock,
      cmd.month_step && status.month_fit |-> days < 16'd31,
      "day count left over exceeds a month")
   `UCAL_ASSERT_ALWAYS(a_year_advance, clock,
      cmd.year_step && !status.year_fit |=> year_ff == $past(year_ff) + 12'd1,
      "year did not advance on a year step")
   `UCAL_ASSERT_ALWAYS(a_century_align, clock,
      cmd.year_step && m100_ff == 7'd0 |->
         (m400_ff == 9'd0 || m400_ff == 9'd100 || m400_ff == 9'd200 || m400_ff == 9'd300),
      "century and quad-century counters out of step")

endmodule
`default_nettype wire

// ===== sv/unix_time_to_calendar.sv =====
// Converts a 32-bit Unix timestamp (seconds since 1970-01-01 00:00 UTC)
// into Gregorian year, month, day, hour, minute and second.
// Request channel: req_valid/req_ready with req_unix_seconds. One beat in
// gives exactly one beat out on the response channel (rsp_valid/rsp_ready).
// Processing, one item at a time:
//   - seconds/minutes/hours split off by constant reciprocal multiplies
//     (/60, /60, /24), each a product step and then a quotient step.
//   - whole days reduced one year per cycle (0..136 years past 1970),
//     leap rule from mod-100 / mod-400 counters.
//   - month walk, one month per cycle (0..11 months).
// A new request is taken only once the response beat has gone and the
// block is back in idle; the year loop is the longest phase of a conversion.
// req_ready is high only while idle. The result sits in the datapath
// registers with rsp_valid high until rsp_ready takes it; a stalled receiver
// holds the block and no new request is taken meanwhile.
// Reset (synchronous, active high) returns the controller to idle and drops
// any item in flight. No configuration registers.
`default_nettype none
module unix_time_to_calendar
   import ucal_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [SECS_W-1:0] req_unix_seconds,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [YEAR_W-1:0] rsp_year_out,
   output logic [MON_W-1:0] rsp_month_out,
   output logic [DAY_W-1:0] rsp_day_out,
   output logic [HOUR_W-1:0] rsp_hour_out,
   output logic [MIN_W-1:0] rsp_minute_out,
   output logic [MIN_W-1:0] rsp_second_out
);

   cmd_type cmd;
   status_type status;

   // sequencer: divide, year walk, month walk, hold result
   ucal_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd(cmd),
      .status(status)
   );

   // divider, day counters and result registers
   ucal_dp u_dp (
      .clock(clock),
      .cmd(cmd),
      .status(status),
      .unix_seconds(req_unix_seconds),
      .year_out(rsp_year_out),
      .month_out(rsp_month_out),
      .day_out(rsp_day_out),
      .hour_out(rsp_hour_out),
      .minute_out(rsp_minute_out),
      .second_out(rsp_second_out)
   );

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import ucal_pkg::*;

   // Watchdog: longest quiet stretch in a correct run is the held receiver
   // (HOLD_CYCLES) on top of a worst-case conversion plus
   // random gaps; the limit is several times that.
   localparam int HOLD_CYCLES = 400;
   localparam int QUIET_LIMIT = 4000;
   // Tail after the last date: worst-case latency with margin.
   localparam int DRAIN_CYCLES = 200;

   // Directed timestamps: field extremes, minute/hour/day/year rollovers,
   // leap days (1972, 2000), a leap year's last day (2008), the
   // non-leap century 2100, the signed 32-bit wrap and two alternating bit patterns.
   localparam logic [SECS_W-1:0] EDGE_STAMPS [24] = '{
      32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd31535999, 32'd31536000,
      32'd68169600, 32'd68255999, 32'd68256000,
      32'd946684799, 32'd946684800, 32'd951782400, 32'd951868800,
      32'd1230767999, 32'd1230768000,
      32'd2147483647, 32'd2147483648,
      32'd4107542399, 32'd4107542400,
      32'hAAAA_AAAA, 32'h5555_5555
   };

   typedef struct packed {
      logic [YEAR_W-1:0] year;
      logic [MON_W-1:0]  month;
      logic [DAY_W-1:0]  day;
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  minute;
      logic [MIN_W-1:0]  second;
   } calendar_type;

   typedef enum {
      KIND_ANY,         // full 32-bit range
      KIND_MONTH_EDGE,  // within a day of a month start, years 1970-2105
      KIND_EARLY,       // first three years, short year walk
      KIND_LATE         // top of the range, longest year walk
   } stim_kind_type;

   // Holds the dates that the accepted timestamps should turn into.
   class scoreboard_type;
      calendar_type      pending_dates[$];
      logic [SECS_W-1:0] pending_stamps[$];
      int                mismatches;
      int                dates_checked;

      function new();
         mismatches = 0;
         dates_checked = 0;
      endfunction

      function int unsigned year_length(int unsigned yr);
         bit leap;
         leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
         return leap ? 366 : 365;
      endfunction

      function int unsigned days_in_month(int unsigned yr, int unsigned mon);
         int unsigned span;
         case (mon)
            MONTH_FEB: span = (year_length(yr) == 366) ? 29 : 28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: span = 30;
            default: span = 31;
         endcase
         return span;
      endfunction

      function calendar_type calendar_of(logic [SECS_W-1:0] stamp);
         int unsigned rest, days, yr, mon, span;
         calendar_type date;
         rest = stamp;
         date.second = MIN_W'(rest % 60);
         rest = rest / 60;
         date.minute = MIN_W'(rest % 60);
         rest = rest / 60;
         date.hour = HOUR_W'(rest % 24);
         days = rest / 24;
         yr = 1970;
         span = year_length(yr);
         while (days >= span) begin
            days -= span;
            yr++;
            span = year_length(yr);
         end
         // December takes whatever is left
         mon = MONTH_JAN;
         while (mon < MONTH_DEC) begin
            span = days_in_month(yr, mon);
            if (days < span) break;
            days -= span;
            mon++;
         end
         date.year = YEAR_W'(yr);
         date.month = MON_W'(mon + 1);
         date.day = DAY_W'(days + 1);
         return date;
      endfunction

      function void note_request(logic [SECS_W-1:0] stamp);
         pending_stamps.push_back(stamp);
         pending_dates.push_back(calendar_of(stamp));
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= 40) $display("MISMATCH %s", msg);
      endtask

      task check_result(calendar_type got);
         calendar_type want;
         logic [SECS_W-1:0] stamp;
         if (pending_dates.size() == 0) begin
            report($sformatf("date %0d-%0d-%0d %0d:%0d:%0d with no timestamp pending",
                             got.year, got.month, got.day,
                             got.hour, got.minute, got.second));
            return;
         end
         want = pending_dates.pop_front();
         stamp = pending_stamps.pop_front();
         dates_checked++;
         if (got.year != want.year)
            report($sformatf("t=%0d year %0d, want %0d", stamp, got.year, want.year));
         if (got.month != want.month)
            report($sformatf("t=%0d month %0d, want %0d", stamp, got.month, want.month));
         if (got.day != want.day)
            report($sformatf("t=%0d day %0d, want %0d", stamp, got.day, want.day));
         if (got.hour != want.hour)
            report($sformatf("t=%0d hour %0d, want %0d", stamp, got.hour, want.hour));
         if (got.minute != want.minute)
            report($sformatf("t=%0d minute %0d, want %0d", stamp, got.minute, want.minute));
         if (got.second != want.second)
            report($sformatf("t=%0d second %0d, want %0d", stamp, got.second, want.second));
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [SECS_W-1:0] req_unix_seconds;
   logic rsp_valid;
   logic rsp_ready;
   logic [YEAR_W-1:0] rsp_year_out;
   logic [MON_W-1:0]  rsp_month_out;
   logic [DAY_W-1:0]  rsp_day_out;
   logic [HOUR_W-1:0] rsp_hour_out;
   logic [MIN_W-1:0]  rsp_minute_out;
   logic [MIN_W-1:0]  rsp_second_out;

   scoreboard_type sb;

   // traffic shaping, set per phase by the stimulus process
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   // hold-off handshake: stimulus bumps the request count, the receiver
   // process serves it and counts the held cycles itself
   int holds_requested = 0;
   int stamps_sent = 0;

   unix_time_to_calendar uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_unix_seconds (req_unix_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_year_out     (rsp_year_out),
      .rsp_month_out    (rsp_month_out),
      .rsp_day_out      (rsp_day_out),
      .rsp_hour_out     (rsp_hour_out),
      .rsp_minute_out   (rsp_minute_out),
      .rsp_second_out   (rsp_second_out)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offer one timestamp; optional idle cycles first. Valid is only dropped
   // while idling, so back-to-back beats keep it high across the edge.
   task automatic send_timestamp(input logic [SECS_W-1:0] stamp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_unix_seconds <= stamp;
      // ready is read before the edge's updates land
      do @(posedge clock); while (!req_ready);
      sb.note_request(stamp);
      stamps_sent++;
   endtask

   task automatic run_random(input int count);
      stim_kind_type kind;
      longint stamp;
      int unsigned yr, mon, days;
      int pick;
      repeat (count) begin
         pick = $urandom_range(99);
         kind = (pick < 35) ? KIND_ANY :
                (pick < 70) ? KIND_MONTH_EDGE :
                (pick < 85) ? KIND_EARLY : KIND_LATE;
         case (kind)
            KIND_ANY: stamp = $urandom;
            KIND_MONTH_EDGE: begin
               yr = $urandom_range(2105, 1970);
               mon = $urandom_range(MONTH_DEC, MONTH_JAN);
               days = 0;
               for (int y = 1970; y < yr; y++) days += sb.year_length(y);
               for (int m = MONTH_JAN; m < mon; m++) days += sb.days_in_month(yr, m);
               // +/- one day around midnight of the 1st
               stamp = longint'(days) * 86400 + longint'($urandom_range(172799)) - 86400;
               if (stamp < 0 || stamp > 64'hFFFF_FFFF) stamp = $urandom;
            end
            KIND_EARLY: stamp = $urandom_range(3 * 31536000);
            default: stamp = 32'hFFFF_FFFF - $urandom_range(50_000_000);
         endcase
         send_timestamp(stamp[SECS_W-1:0]);
      end
   endtask

   // Receiver: checks a beat at each edge, then picks next cycle's ready.
   initial begin
      int holds_served;
      int hold_left;
      calendar_type got;
      holds_served = 0;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.year = rsp_year_out;
            got.month = rsp_month_out;
            got.day = rsp_day_out;
            got.hour = rsp_hour_out;
            got.minute = rsp_minute_out;
            got.second = rsp_second_out;
            sb.check_result(got);
         end
         if (holds_served != holds_requested) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Watchdog: cycles with no beat on either channel.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("timeout: %0d cycles without a beat", QUIET_LIMIT);
            $display("[unix_time_to_calendar] ERROR");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_unix_seconds = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed edges, back to back
      foreach (EDGE_STAMPS[i]) send_timestamp(EDGE_STAMPS[i]);

      // random phases: free-running, idle sender, stalling receiver, both
      run_random(150);
      send_idle_pct = 85;
      run_random(120);
      send_idle_pct = 0;
      rsp_stall_pct = 85;
      run_random(120);
      send_idle_pct = 24;
      rsp_stall_pct = 24;
      run_random(140);

      // long receiver hold while the sender keeps offering: the block holds
      // its finished date and must keep req_ready low
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      holds_requested++;
      run_random(120);
      req_valid <= 1'b0;

      while (sb.pending_dates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d timestamps (%0d directed), %0d dates checked, %0d mismatches",
               stamps_sent, $size(EDGE_STAMPS), sb.dates_checked, sb.mismatches);
      $display("traffic: free-running, 85%% idle sender, 85%% stalled receiver, %s",
               "24% both, one long receiver hold");
      if (sb.mismatches == 0) begin
         $display("[unix_time_to_calendar] OK");
      end else begin
         $display("[unix_time_to_calendar] ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ucal_pkg.sv
sv/ucal_ctrl.sv
sv/ucal_dp.sv
sv/unix_time_to_calendar.sv
tb/tb.sv
